[hdl/ralp_pkg.sv]
// Shared types, widths and constants for the ring light hit and density pipeline.
package ralp_pkg;

  localparam int COORD_W = 32;
  localparam int UNIT_W  = 18;
  localparam int RAD_W   = 31;
  localparam int Q_W     = 31;
  localparam int COS_W   = 36;
  localparam int NUM_W   = 51;
  localparam int DEN2_W  = 98;
  localparam int NUK_W   = 93;

  localparam logic [Q_W-1:0] INV_PI_Q32  = 31'd1367130551;
  localparam logic [Q_W-1:0] DENSITY_MAX = '1;

  typedef enum logic [2:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_NORMAL_X,
    REG_NORMAL_Y,
    REG_NORMAL_Z,
    REG_OUTER_RADIUS,
    REG_INNER_RADIUS
  } reg_index_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic signed [UNIT_W-1:0]  normal_x;
    logic signed [UNIT_W-1:0]  normal_y;
    logic signed [UNIT_W-1:0]  normal_z;
    logic [RAD_W-1:0]          outer_radius;
    logic [RAD_W-1:0]          inner_radius;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [UNIT_W-1:0]  dir_x;
    logic signed [UNIT_W-1:0]  dir_y;
    logic signed [UNIT_W-1:0]  dir_z;
  } ray_t;

  typedef struct packed {
    ray_t             ray;
    logic [COS_W-1:0] cos;
    logic             miss;
  } ray_side_t;

  typedef struct packed {
    logic           hit;
    logic [Q_W-1:0] hit_dist;
  } hit_side_t;

endpackage

[hdl/ralp_front.sv]
// Dot products with the light normal and setup of the hit distance division.
module ralp_front
  import ralp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  ray_t             ray,
  input  cfg_t             cfg,
  output logic             out_valid,
  output logic [COS_W-1:0] rem0,
  output logic [COS_W-1:0] den,
  output logic [Q_W-1:0]   low,
  output logic             sat,
  output ray_side_t        side
);

  logic signed [COORD_W-1:0] p [3];
  logic signed [COORD_W-1:0] c [3];
  logic signed [UNIT_W-1:0]  w [3];
  logic signed [UNIT_W-1:0]  n [3];
  logic signed [COORD_W:0]   diff [3];

  logic                  v1;
  ray_t                  ray1;
  logic signed [35:0]    wn [3];
  logic signed [50:0]    pn [3];

  logic                  v2;
  ray_t                  ray2;
  logic [COS_W-1:0]      cos2;
  logic [NUM_W-1:0]      a2;
  logic                  miss2;

  logic signed [37:0]    dn_sum;
  logic signed [52:0]    num_sum;

  always_comb begin
    p[0] = ray.origin_x; p[1] = ray.origin_y; p[2] = ray.origin_z;
    w[0] = ray.dir_x;    w[1] = ray.dir_y;    w[2] = ray.dir_z;
    c[0] = cfg.center_x; c[1] = cfg.center_y; c[2] = cfg.center_z;
    n[0] = cfg.normal_x; n[1] = cfg.normal_y; n[2] = cfg.normal_z;
    for (int k = 0; k < 3; k++) begin
      diff[k] = $signed({c[k][COORD_W-1], c[k]}) - $signed({p[k][COORD_W-1], p[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      ray1 <= ray;
      for (int k = 0; k < 3; k++) begin
        wn[k] <= w[k] * n[k];
        pn[k] <= diff[k] * n[k];
      end
    end
  end

  always_comb begin
    dn_sum  = 38'(wn[0]) + 38'(wn[1]) + 38'(wn[2]);
    num_sum = 53'(pn[0]) + 53'(pn[1]) + 53'(pn[2]);
  end

  // back-facing, grazing, or hit behind the origin
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      ray2  <= ray1;
      cos2  <= COS_W'(-dn_sum);
      a2    <= NUM_W'(-num_sum);
      miss2 <= !dn_sum[37] || (!num_sum[52] && (num_sum != '0));
    end
  end

  // t = floor(a * 2^16 / cos); overflow when a / 2^15 >= cos
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      rem0      <= a2[NUM_W-1:15];
      den       <= cos2;
      low       <= {a2[14:0], 16'b0};
      sat       <= a2[NUM_W-1:15] >= cos2;
      side.ray  <= ray2;
      side.cos  <= cos2;
      side.miss <= miss2;
    end
  end

endmodule

[hdl/ralp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module ralp_div #(
  parameter int DEN_W  = 36,
  parameter int QUO_W  = 31,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  rem0,
  input  logic [DEN_W-1:0]  den,
  input  logic [QUO_W-1:0]  low,
  input  logic              sat,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quot,
  output logic              out_sat,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld    [1:QUO_W];
  logic [DEN_W-1:0]  rem_s  [1:QUO_W];
  logic [DEN_W-1:0]  den_s  [1:QUO_W];
  logic [QUO_W-1:0]  low_s  [1:QUO_W];
  logic [QUO_W-1:0]  quo_s  [1:QUO_W];
  logic              sat_s  [1:QUO_W];
  logic [SIDE_W-1:0] side_s [1:QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic              v_in;
    logic [DEN_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [QUO_W-1:0]  low_in;
    logic [QUO_W-1:0]  quo_in;
    logic              sat_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_sub;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = rem0;
      assign den_in  = den;
      assign low_in  = low;
      assign quo_in  = '0;
      assign sat_in  = sat;
      assign side_in = side;
    end else begin : g_next
      assign v_in    = vld[i];
      assign rem_in  = rem_s[i];
      assign den_in  = den_s[i];
      assign low_in  = low_s[i];
      assign quo_in  = quo_s[i];
      assign sat_in  = sat_s[i];
      assign side_in = side_s[i];
    end

    always_comb begin
      rem_sh  = {rem_in, low_in[QUO_W-1]};
      rem_sub = rem_sh - {1'b0, den_in};
      ge      = rem_sh >= {1'b0, den_in};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= v_in;
      end
      if (en) begin
        rem_s[i+1]  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        den_s[i+1]  <= den_in;
        low_s[i+1]  <= low_in << 1;
        quo_s[i+1]  <= {quo_in[QUO_W-2:0], ge};
        sat_s[i+1]  <= sat_in;
        side_s[i+1] <= side_in;
      end
    end
  end

  assign out_valid = vld[QUO_W];
  assign quot      = quo_s[QUO_W];
  assign out_sat   = sat_s[QUO_W];
  assign out_side  = side_s[QUO_W];

endmodule

[hdl/ralp_geom.sv]
// Plane hit point, annulus test and setup of the density division.
module ralp_geom
  import ralp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [Q_W-1:0]    t_in,
  input  logic              t_sat,
  input  ray_side_t         side,
  input  cfg_t              cfg,
  output logic              out_valid,
  output logic [DEN2_W-1:0] rem0,
  output logic [DEN2_W-1:0] den,
  output logic [Q_W-1:0]    low,
  output logic              sat,
  output hit_side_t         out_side
);

  logic signed [COORD_W-1:0] p [3];
  logic signed [COORD_W-1:0] c [3];
  logic signed [UNIT_W-1:0]  w [3];

  // stage a
  logic               va, missa;
  logic [Q_W-1:0]     ta;
  logic [COS_W-1:0]   cosa;
  logic signed [COORD_W:0] pc_a [3];
  logic signed [49:0] tw [3];
  logic [61:0]        tt, rr_o, rr_i;

  // stage b
  logic               vb, missb;
  logic [Q_W-1:0]     tb;
  logic [COS_W-1:0]   cosb;
  logic [RAD_W-1:0]   m [3];
  logic [61:0]        area, tkh, tkl, rr_ob, rr_ib;
  logic signed [34:0] d [3];
  logic [34:0]        mag [3];
  logic               big;

  // stage c
  logic               vc, missc;
  logic [Q_W-1:0]     tc;
  logic [61:0]        mm [3];
  logic [66:0]        deh, del;
  logic [NUK_W-1:0]   nukc;
  logic [61:0]        rr_oc, rr_ic;

  // stage d
  logic               vd, hitd;
  logic [Q_W-1:0]     td;
  logic [DEN2_W-1:0]  ded;
  logic [NUK_W-1:0]   nukd;
  logic [63:0]        dsq;

  always_comb begin
    p[0] = side.ray.origin_x; p[1] = side.ray.origin_y; p[2] = side.ray.origin_z;
    w[0] = side.ray.dir_x;    w[1] = side.ray.dir_y;    w[2] = side.ray.dir_z;
    c[0] = cfg.center_x;      c[1] = cfg.center_y;      c[2] = cfg.center_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      ta    <= t_in;
      missa <= side.miss || t_sat;
      cosa  <= side.cos;
      for (int k = 0; k < 3; k++) begin
        pc_a[k] <= $signed({p[k][COORD_W-1], p[k]}) - $signed({c[k][COORD_W-1], c[k]});
        tw[k]   <= $signed({1'b0, t_in}) * w[k];
      end
      tt   <= t_in * t_in;
      rr_o <= cfg.outer_radius * cfg.outer_radius;
      rr_i <= cfg.inner_radius * cfg.inner_radius;
    end
  end

  // hit offset from the center, floor rounding on t*w
  always_comb begin
    big = 1'b0;
    for (int k = 0; k < 3; k++) begin
      d[k]   = 35'(pc_a[k]) + 35'(tw[k] >>> 16);
      mag[k] = d[k][34] ? 35'(-d[k]) : 35'(d[k]);
      big    = big || (mag[k] > 35'(cfg.outer_radius));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
    if (en) begin
      tb    <= ta;
      missb <= missa || big;
      cosb  <= cosa;
      for (int k = 0; k < 3; k++) begin
        m[k] <= mag[k][RAD_W-1:0];
      end
      area  <= (rr_o >= rr_i) ? (rr_o - rr_i) : '0;
      tkh   <= tt[61:31] * INV_PI_Q32;
      tkl   <= tt[30:0] * INV_PI_Q32;
      rr_ob <= rr_o;
      rr_ib <= rr_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
    if (en) begin
      tc    <= tb;
      missc <= missb;
      for (int k = 0; k < 3; k++) begin
        mm[k] <= m[k] * m[k];
      end
      deh   <= cosb * area[61:31];
      del   <= cosb * area[30:0];
      nukc  <= (NUK_W'(tkh) << 31) + NUK_W'(tkl);
      rr_oc <= rr_ob;
      rr_ic <= rr_ib;
    end
  end

  always_comb begin
    dsq = 64'(mm[0]) + 64'(mm[1]) + 64'(mm[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
    if (en) begin
      td   <= tc;
      hitd <= !missc && (dsq <= 64'(rr_oc)) && (dsq >= 64'(rr_ic));
      ded  <= (DEN2_W'(deh) << 31) + DEN2_W'(del);
      nukd <= nukc;
    end
  end

  // density = floor(nuk * 2^16 / de); saturates when nuk / 2^15 >= de (also de = 0)
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd;
    end
    if (en) begin
      rem0              <= DEN2_W'(nukd[NUK_W-1:15]);
      den               <= ded;
      low               <= {nukd[14:0], 16'b0};
      sat               <= DEN2_W'(nukd[NUK_W-1:15]) >= ded;
      out_side.hit      <= hitd;
      out_side.hit_dist <= td;
    end
  end

endmodule

[hdl/ray_annulus_light_pdf.sv]
// Top level: ring area light ray hit test and solid-angle density pipeline.
// Usage:
//   Rays enter on the s_ group, one request per cycle when s_tready is high.
//   Results leave on the m_ group in input order: m_tuser is the hit flag,
//   m_tdata holds density and hit distance, both zero on a miss.
//   The user must write light center, normal and radii on the cfg_ port only while idle (not enforced).
// Path: an accepted ray passes three front stages, 31 stages of the
//   distance divider, five geometry stages, 31 stages of the density
//   divider and the output register on its way to m_tvalid.
// Throughput: one ray per cycle when not stalled; each divider retires one
//   quotient bit per stage, so every stage holds a separate ray.
// Stall: the whole pipeline holds while a result waits on a low m_tready,
//   and s_tready is low for exactly those cycles, so no request is lost or
//   repeated.
// Reset: rst clears all valid bits and loads the light registers with
//   center (0,0,0), normal (0,0,-1), outer radius 1.0 and inner radius 0.
module ray_annulus_light_pdf
  import ralp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, 2 zero bits
  input  logic [151:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // density, hit_distance, 2 zero bits
  output logic [63:0]  m_tdata,
  // hit
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int SIDE1_W = $bits(ray_side_t);
  localparam int SIDE2_W = $bits(hit_side_t);

  cfg_t             cfg;
  ray_t             ray;
  logic             en;

  logic             f_valid, f_sat;
  logic [COS_W-1:0] f_rem0, f_den;
  logic [Q_W-1:0]   f_low;
  ray_side_t        f_side;

  logic             d1_valid, d1_sat;
  logic [Q_W-1:0]   d1_quot;
  logic [SIDE1_W-1:0] d1_side;

  logic              g_valid, g_sat;
  logic [DEN2_W-1:0] g_rem0, g_den;
  logic [Q_W-1:0]    g_low;
  hit_side_t         g_side;

  logic             d2_valid, d2_sat;
  logic [Q_W-1:0]   d2_quot;
  logic [SIDE2_W-1:0] d2_side;
  hit_side_t        d2_hs;

  logic             out_valid, out_hit;
  logic [Q_W-1:0]   out_density, out_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x     <= '0;
      cfg.center_y     <= '0;
      cfg.center_z     <= '0;
      cfg.normal_x     <= '0;
      cfg.normal_y     <= '0;
      cfg.normal_z     <= -18'sd65536;
      cfg.outer_radius <= 31'd65536;
      cfg.inner_radius <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_CENTER_X:     cfg.center_x     <= cfg_data;
        REG_CENTER_Y:     cfg.center_y     <= cfg_data;
        REG_CENTER_Z:     cfg.center_z     <= cfg_data;
        REG_NORMAL_X:     cfg.normal_x     <= cfg_data[UNIT_W-1:0];
        REG_NORMAL_Y:     cfg.normal_y     <= cfg_data[UNIT_W-1:0];
        REG_NORMAL_Z:     cfg.normal_z     <= cfg_data[UNIT_W-1:0];
        REG_OUTER_RADIUS: cfg.outer_radius <= cfg_data[RAD_W-1:0];
        REG_INNER_RADIUS: cfg.inner_radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ray.origin_x = s_tdata[31:0];
    ray.origin_y = s_tdata[63:32];
    ray.origin_z = s_tdata[95:64];
    ray.dir_x    = s_tdata[113:96];
    ray.dir_y    = s_tdata[131:114];
    ray.dir_z    = s_tdata[149:132];
  end

  assign en       = !out_valid || m_tready;
  assign s_tready = en;

  ralp_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid), .ray(ray), .cfg(cfg),
    .out_valid(f_valid), .rem0(f_rem0), .den(f_den), .low(f_low),
    .sat(f_sat), .side(f_side)
  );

  ralp_div #(.DEN_W(COS_W), .QUO_W(Q_W), .SIDE_W(SIDE1_W)) u_div_t (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(f_valid), .rem0(f_rem0), .den(f_den), .low(f_low),
    .sat(f_sat), .side(f_side),
    .out_valid(d1_valid), .quot(d1_quot), .out_sat(d1_sat), .out_side(d1_side)
  );

  ralp_geom u_geom (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d1_valid), .t_in(d1_quot), .t_sat(d1_sat),
    .side(ray_side_t'(d1_side)), .cfg(cfg),
    .out_valid(g_valid), .rem0(g_rem0), .den(g_den), .low(g_low),
    .sat(g_sat), .out_side(g_side)
  );

  ralp_div #(.DEN_W(DEN2_W), .QUO_W(Q_W), .SIDE_W(SIDE2_W)) u_div_pdf (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(g_valid), .rem0(g_rem0), .den(g_den), .low(g_low),
    .sat(g_sat), .side(g_side),
    .out_valid(d2_valid), .quot(d2_quot), .out_sat(d2_sat), .out_side(d2_side)
  );

  assign d2_hs = hit_side_t'(d2_side);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d2_valid;
    end
    if (en) begin
      out_hit     <= d2_hs.hit;
      out_density <= !d2_hs.hit ? '0 : (d2_sat ? DENSITY_MAX : d2_quot);
      out_dist    <= d2_hs.hit ? d2_hs.hit_dist : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_hit;
  assign m_tdata  = {2'b00, out_dist, out_density};

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_hit) |-> (out_density == '0 && out_dist == '0))
    else $error("miss result carries nonzero fields");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(d2_valid) && $stable(g_valid) && $stable(f_valid)))
    else $error("pipeline moved during stall");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !d2_valid && !f_valid))
    else $error("valid bits not cleared by reset");
`endif

endmodule
